// ===== design/wpm_pkg.sv =====
// Shared types and constants for the glob wildcard matcher.
// Depends on nothing; every other design file imports it.
package wpm_pkg;

   // Pattern capacity in bytes and the derived length width
   localparam int PatternChars = 64;
   localparam int LenW         = $clog2(PatternChars + 1);

   // Wildcard byte codes
   localparam logic [7:0] StarByte = 8'd42;
   localparam logic [7:0] AnyByte  = 8'd63;

   // Command carried by each input word
   typedef enum logic [1:0] {
      ModeStart  = 2'd0,
      ModeAppend = 2'd1,
      ModeText   = 2'd2,
      ModeEnd    = 2'd3
   } mode_type;

   // One registered input word as seen by the processing logic
   typedef struct packed {
      logic            fire;
      mode_type        mode;
      logic [7:0]      byte_value;
   } op_type;

   // Decoded view of the stored pattern
   typedef struct packed {
      logic [LenW-1:0]         len;
      logic [PatternChars-1:0] live;
      logic [PatternChars-1:0] star;
      logic [PatternChars-1:0] any;
      logic                    overflow;
   } pat_view_type;

endpackage

// ===== design/wpm_store.sv =====
// Pattern store: byte cells, length, star-run collapse and overflow flag.
// Depends on wpm_pkg.
module wpm_store
   import wpm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  op_type       op,
   output pat_view_type view,
   output logic [7:0]   pat_bytes [PatternChars]
);

   logic [7:0]      bytes_ff [PatternChars];
   logic [LenW-1:0] len_ff, len_in;
   logic            last_star_ff, last_star_in;
   logic            ovf_ff, ovf_in;
   logic            append, is_star, collapse, full, write;

   // Decide what an appended byte does
   always_comb begin
      append   = op.fire && (op.mode == ModeAppend);
      is_star  = (op.byte_value == StarByte);
      collapse = is_star && last_star_ff;
      full     = (len_ff == LenW'(PatternChars));
      write    = append && !collapse && !full;
   end

   // Next length, star tracking and overflow
   always_comb begin
      len_in       = len_ff;
      last_star_in = last_star_ff;
      ovf_in       = ovf_ff;
      if (op.fire && op.mode == ModeStart) begin
         len_in       = '0;
         last_star_in = 1'b0;
         ovf_in       = 1'b0;
      end else if (write) begin
         len_in       = len_ff + LenW'(1);
         last_star_in = is_star;
      end else if (append && !collapse) begin
         ovf_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         last_star_ff <= 1'b0;
         ovf_ff       <= 1'b0;
      end else begin
         len_ff       <= len_in;
         last_star_ff <= last_star_in;
         ovf_ff       <= ovf_in;
      end
   end

   // Write the byte cell at the current length
   always_ff @(posedge clock) begin
      for (int i = 0; i < PatternChars; i++) begin
         if (write && len_ff == LenW'(i)) begin
            bytes_ff[i] <= op.byte_value;
         end
      end
   end

   // Decode each cell; cells past the length are masked off
   always_comb begin
      view.len      = len_ff;
      view.overflow = ovf_ff;
      for (int i = 0; i < PatternChars; i++) begin
         view.live[i] = (len_ff > LenW'(i));
         view.star[i] = view.live[i] && (bytes_ff[i] == StarByte);
         view.any[i]  = view.live[i] && (bytes_ff[i] == AnyByte);
         pat_bytes[i] = bytes_ff[i];
      end
   end

endmodule

// ===== design/wpm_nfa.sv =====
// Active-position vector: one parallel update per text byte.
// Depends on wpm_pkg; reads the decoded pattern from wpm_store.
module wpm_nfa
   import wpm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  op_type       op,
   input  pat_view_type view,
   input  logic [7:0]   pat_bytes [PatternChars],
   output logic         matched
);

   localparam logic [PatternChars:0] Restart = {{PatternChars{1'b0}}, 1'b1};

   // Vector held before star closure; closure is applied on read
   logic [PatternChars:0] raw_ff, raw_in;
   logic [PatternChars:0] eff, step;

   // Close over stars; stored stars never sit side by side, so one step suffices
   always_comb begin
      eff = raw_ff;
      for (int i = 0; i < PatternChars; i++) begin
         eff[i+1] = raw_ff[i+1] | (raw_ff[i] & view.star[i]);
      end
   end

   // Advance every active position by the text byte
   always_comb begin
      step = '0;
      for (int i = 0; i < PatternChars; i++) begin
         if (eff[i] && view.live[i]) begin
            if (view.star[i]) begin
               step[i] = 1'b1;
            end else if (view.any[i] || pat_bytes[i] == op.byte_value) begin
               step[i+1] = 1'b1;
            end
         end
      end
   end

   assign matched = eff[view.len];

   // Pick the next vector
   always_comb begin
      raw_in = raw_ff;
      if (op.fire) begin
         unique case (op.mode)
            ModeText: begin
               raw_in = step;
            end
            ModeStart, ModeAppend, ModeEnd: begin
               raw_in = Restart;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff <= Restart;
      end else begin
         raw_ff <= raw_in;
      end
   end

endmodule

// ===== design/wildcard_pattern_match_core.sv =====
// Glob wildcard matcher: '*' matches any run of bytes, '?' exactly one byte.
// Each accepted word goes into an input register, is then processed against the
// pattern cells and the active-position vector, and an end-of-text word leaves its
// result in an output register. One word is taken every cycle; the only hold-up is
// an end-of-text word waiting while the previous result is still stalled. No
// clearing pass follows reset. Depends on wpm_pkg, wpm_store and wpm_nfa.
module wildcard_pattern_match_core
   import wpm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_byte_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_matched,
   output logic       rsp_pattern_overflow
);

   logic         in_valid_ff;
   mode_type     in_mode_ff;
   logic [7:0]   in_byte_ff;
   logic         rsp_valid_ff;
   logic         rsp_matched_ff;
   logic         rsp_ovf_ff;
   logic         proc;
   logic         fire_end;
   logic         matched;
   op_type       op;
   pat_view_type view;
   logic [7:0]   pat_bytes [PatternChars];

   // Process the held word unless it needs the output register while that is stalled
   always_comb begin
      proc      = in_valid_ff &&
                  ((in_mode_ff != ModeEnd) || !(rsp_valid_ff && rsp_stall));
      fire_end  = proc && (in_mode_ff == ModeEnd);
      req_stall = in_valid_ff && !proc;
      op.fire       = proc;
      op.mode       = in_mode_ff;
      op.byte_value = in_byte_ff;
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (proc) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_mode_ff <= mode_type'(req_mode);
         in_byte_ff <= req_byte_value;
      end
   end

   wpm_store u_store (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .view      (view),
      .pat_bytes (pat_bytes)
   );

   wpm_nfa u_nfa (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .view      (view),
      .pat_bytes (pat_bytes),
      .matched   (matched)
   );

   // Output register: load on end of text, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire_end) begin
         rsp_matched_ff <= matched;
         rsp_ovf_ff     <= view.overflow;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_matched          = rsp_matched_ff;
   assign rsp_pattern_overflow = rsp_ovf_ff;

   // A new result only follows a processed end-of-text word
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fire_end))
      else $error("result appeared without an end-of-text word");

   // A word held back is neither lost nor altered
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !proc) |=> (in_valid_ff && $stable(in_mode_ff) && $stable(in_byte_ff)))
      else $error("held input word changed");

   // Pattern length stays within capacity
   a_len_cap: assert property (@(posedge clock) disable iff (reset)
      view.len <= LenW'(PatternChars))
      else $error("pattern length beyond capacity");

   // Star runs are collapsed, which the one-step closure relies on
   a_no_star_pair: assert property (@(posedge clock) disable iff (reset)
      (view.star & (view.star >> 1)) == '0)
      else $error("adjacent stars in pattern store");

endmodule

// ===== verif/wildcard_pattern_match_core_tb.sv =====
// Self-checking testbench for wildcard_pattern_match_core: streams pattern and text words,
// predicts each match verdict in a local glob matcher and checks every result word.
// Depends on wpm_pkg and the design files under design/.
module wildcard_pattern_match_core_tb;
   import wpm_pkg::*;

   typedef struct {
      mode_type   mode;
      logic [7:0] byte_value;
   } req_word_type;

   typedef struct {
      logic matched;
      logic overflow;
   } verdict_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_mode = ModeStart;
   logic [7:0] req_byte_value = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_matched;
   logic       rsp_pattern_overflow;

   req_word_type pending_words[$];
   verdict_type  expected_verdicts[$];
   int           sender_idle_pct = 0;
   int           rsp_stall_pct = 0;
   int           hold_requests = 0;
   int           holds_served = 0;
   int           hold_left = 0;
   int           mismatches = 0;
   int           stim_words = 0;

   // Local copy of the matcher state
   logic [7:0]        pat_bytes [PatternChars];
   int                pat_len;
   logic              pat_ovf;
   logic [PatternChars:0] live_pos;

   wildcard_pattern_match_core u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_mode             (req_mode),
      .req_byte_value       (req_byte_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_matched          (rsp_matched),
      .rsp_pattern_overflow (rsp_pattern_overflow)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Extend every active position over a following star, which may match nothing
   function automatic logic [PatternChars:0] star_closure(logic [PatternChars:0] v);
      for (int i = 0; i < pat_len; i++) begin
         if (v[i] && pat_bytes[i] == StarByte) v[i+1] = 1'b1;
      end
      return v;
   endfunction

   function automatic logic [PatternChars:0] start_positions();
      logic [PatternChars:0] v;
      v = '0;
      v[0] = 1'b1;
      return star_closure(v);
   endfunction

   // Advance the local matcher by one accepted word
   task automatic apply_word(mode_type m, logic [7:0] b);
      logic [PatternChars:0] nxt;
      verdict_type           v;
      case (m)
         ModeStart: begin
            pat_len = 0;
            pat_ovf = 1'b0;
            live_pos = start_positions();
         end
         ModeAppend: begin
            if (b == StarByte && pat_len > 0 && pat_bytes[pat_len-1] == StarByte) begin
               // fold into the preceding star
            end else if (pat_len >= PatternChars) begin
               pat_ovf = 1'b1;
            end else begin
               pat_bytes[pat_len] = b;
               pat_len++;
            end
            live_pos = start_positions();
         end
         ModeText: begin
            nxt = '0;
            for (int i = 0; i < pat_len; i++) begin
               if (live_pos[i]) begin
                  if (pat_bytes[i] == StarByte) nxt[i] = 1'b1;
                  else if (pat_bytes[i] == AnyByte || pat_bytes[i] == b) nxt[i+1] = 1'b1;
               end
            end
            live_pos = star_closure(nxt);
         end
         default: begin
            v.matched = live_pos[pat_len];
            v.overflow = pat_ovf;
            expected_verdicts.push_back(v);
            live_pos = start_positions();
         end
      endcase
   endtask

   task automatic push_word(mode_type m, logic [7:0] b);
      req_word_type w;
      w.mode = m;
      w.byte_value = b;
      pending_words.push_back(w);
      stim_words++;
   endtask

   // Small alphabet with wildcards, sometimes any byte
   function automatic logic [7:0] pattern_char();
      int r;
      r = $urandom_range(99);
      if (r < 30) return 8'h61;
      if (r < 50) return 8'h62;
      if (r < 60) return 8'h63;
      if (r < 75) return StarByte;
      if (r < 88) return AnyByte;
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] text_char();
      int r;
      r = $urandom_range(99);
      if (r < 35) return 8'h61;
      if (r < 65) return 8'h62;
      if (r < 80) return 8'h63;
      return 8'($urandom_range(255));
   endfunction

   // One pattern followed by a few texts, about half built to match
   task automatic push_sequence(bit long_pattern);
      logic [7:0] pat[$];
      logic [7:0] c;
      int         n;
      push_word(ModeStart, 8'($urandom_range(255)));
      n = long_pattern ? $urandom_range(62, 70) : $urandom_range(0, 8);
      repeat (n) begin
         c = pattern_char();
         pat.push_back(c);
         push_word(ModeAppend, c);
      end
      repeat ($urandom_range(1, 3)) begin
         if ($urandom_range(1)) begin
            foreach (pat[i]) begin
               if (pat[i] == StarByte) begin
                  repeat ($urandom_range(0, 3)) push_word(ModeText, text_char());
               end else if (pat[i] == AnyByte) begin
                  push_word(ModeText, 8'($urandom_range(255)));
               end else begin
                  push_word(ModeText, pat[i]);
               end
            end
         end else begin
            repeat ($urandom_range(0, 8)) push_word(ModeText, text_char());
         end
         push_word(ModeEnd, 8'($urandom_range(255)));
      end
   endtask

   // Drive request words; predict each one as it is accepted
   always @(posedge clock) begin : drive_words
      req_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
         pat_len = 0;
         pat_ovf = 1'b0;
         live_pos = start_positions();
      end else begin
         if (req_valid && !req_stall) apply_word(mode_type'(req_mode), req_byte_value);
         if (!req_valid || !req_stall) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               w = pending_words.pop_front();
               req_valid <= 1'b1;
               req_mode <= w.mode;
               req_byte_value <= w.byte_value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Stall the result side at random, or hold it off for a long stretch on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left <= 400;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   task automatic note_mismatch(string what, verdict_type want);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s: expected matched=%0b overflow=%0b, got matched=%0b overflow=%0b",
                  what, want.matched, want.overflow, rsp_matched, rsp_pattern_overflow);
      end
   endtask

   // Check each accepted result word against the oldest expected verdict
   always @(posedge clock) begin : check_verdicts
      verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            want.matched = 1'bx;
            want.overflow = 1'bx;
            note_mismatch("unexpected result word", want);
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_matched !== want.matched || rsp_pattern_overflow !== want.overflow)
               note_mismatch("verdict mismatch", want);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int phase_start;
      int wait_cycles;
      bit first;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 4; phase++) begin
         @(negedge clock);
         sender_idle_pct = (phase == 1) ? 55 : (phase == 3) ? 32 : 0;
         rsp_stall_pct = (phase == 2) ? 55 : (phase == 3) ? 32 : 0;
         if (phase == 0) begin
            // empty text against the empty pattern after reset
            push_word(ModeEnd, 8'hFF);
            // star run collapses; star-only pattern matches empty and short text
            push_word(ModeStart, 8'h00);
            push_word(ModeAppend, StarByte);
            push_word(ModeAppend, StarByte);
            push_word(ModeAppend, StarByte);
            push_word(ModeEnd, 8'h00);
            push_word(ModeText, 8'h78);
            push_word(ModeEnd, 8'hFF);
            // trailing star matches nothing
            push_word(ModeStart, 8'hFF);
            push_word(ModeAppend, 8'h61);
            push_word(ModeAppend, 8'h62);
            push_word(ModeAppend, StarByte);
            push_word(ModeText, 8'h61);
            push_word(ModeText, 8'h62);
            push_word(ModeEnd, 8'h00);
            // zero and all-ones bytes are plain literals; question mark takes one byte
            push_word(ModeStart, 8'h00);
            push_word(ModeAppend, 8'h00);
            push_word(ModeAppend, AnyByte);
            push_word(ModeAppend, 8'hFF);
            push_word(ModeText, 8'h00);
            push_word(ModeText, 8'h5A);
            push_word(ModeText, 8'hFF);
            push_word(ModeEnd, 8'hFF);
            // pattern change in the middle of a text restarts matching
            push_word(ModeText, 8'h00);
            push_word(ModeAppend, 8'h71);
            push_word(ModeText, 8'h71);
            push_word(ModeEnd, 8'h00);
         end
         // random sequences; the first phase opens with a long pattern near or past capacity
         phase_start = stim_words;
         first = 1'b1;
         while (stim_words - phase_start < 100) begin
            if (!first && $urandom_range(9) == 0) begin
               repeat ($urandom_range(1, 4))
                  push_word(mode_type'($urandom_range(3)), 8'($urandom_range(255)));
            end else begin
               push_sequence((first && phase == 0) || $urandom_range(29) == 0);
            end
            first = 1'b0;
         end
         // in the first phase, hold off the result side so the block backs up into its input
         if (phase == 0) hold_requests++;
         while (pending_words.size() != 0 || req_valid) @(negedge clock);
      end
      wait_cycles = 0;
      while (expected_verdicts.size() != 0 && wait_cycles < 20000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (10) @(negedge clock);
      if (mismatches == 0 && expected_verdicts.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
